FILE: rtl/core/tdpt_pkg.sv
// shared widths and types for the trial division prime test
`default_nettype none

package tdpt_pkg;

    // width of the candidate port
    localparam int CAND_W = 32;
    // candidate bits that take part in the test (at most CAND_W)
    localparam int WIDTH = 32;
    // trial divisor width, holds one past the integer square root
    localparam int DW = (WIDTH + 1) / 2 + 1;
    // running square of the divisor
    localparam int SQW = 2 * ((WIDTH + 1) / 2) + 1;
    // bit index into the candidate
    localparam int BCW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_HOLD   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/trial_division_prime_test_core.sv
// trial division prime test, top level
`default_nettype none

// One candidate word in, one is_prime word out. The block tries divisors
// 2, 3, 4, ... until one divides the candidate or the divisor squared
// exceeds the candidate; each trial compares the running square with the
// candidate, then runs a bit-serial restoring remainder over the WIDTH
// candidate bits. Zero and one report not prime. in_stall stays high from
// acceptance until the result is loaded into the output register; a result
// waiting there does not stall the input side.
module trial_division_prime_test_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [tdpt_pkg::CAND_W-1:0] candidate,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            is_prime
);

    tdpt_pkg::state_t                 state_reg, state_next;
    logic [tdpt_pkg::WIDTH-1:0]       n_reg, n_next;
    logic [tdpt_pkg::DW-1:0]          d_reg, d_next;
    logic [tdpt_pkg::SQW-1:0]         sq_reg, sq_next;
    logic [tdpt_pkg::DW-1:0]          rem_reg, rem_next;
    logic [tdpt_pkg::BCW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic                             res_reg, res_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             is_prime_reg, is_prime_next;

    logic                             out_free;
    logic                             fin;
    logic                             fin_val;
    logic [tdpt_pkg::DW:0]            trial;
    logic                             trial_ge;
    logic [tdpt_pkg::DW-1:0]          rem_new;

    assign in_stall  = (state_reg != tdpt_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // shared remainder step
    assign trial    = {rem_reg, n_reg[bit_cnt_reg]};
    assign trial_ge = (trial >= {1'b0, d_reg});
    assign rem_new  = trial_ge ? tdpt_pkg::DW'(trial - {1'b0, d_reg})
                               : tdpt_pkg::DW'(trial);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        is_prime_next  = is_prime_reg;
        fin            = 1'b0;
        fin_val        = 1'b0;

        unique case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = candidate[tdpt_pkg::WIDTH-1:0];
                    d_next     = tdpt_pkg::DW'(2);
                    sq_next    = tdpt_pkg::SQW'(4);
                    state_next = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_CHECK:
            begin
                if (n_reg < tdpt_pkg::WIDTH'(2))
                begin
                    fin     = 1'b1;
                    fin_val = 1'b0;
                end
                else if (sq_reg > tdpt_pkg::SQW'(n_reg))
                begin
                    fin     = 1'b1;
                    fin_val = 1'b1;
                end
                else
                begin
                    rem_next     = '0;
                    bit_cnt_next = tdpt_pkg::BCW'(tdpt_pkg::WIDTH - 1);
                    state_next   = tdpt_pkg::ST_DIVIDE;
                end
            end
            tdpt_pkg::ST_DIVIDE:
            begin
                rem_next     = rem_new;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    if (rem_new == '0)
                    begin
                        fin     = 1'b1;
                        fin_val = 1'b0;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        d_next     = d_reg + 1'b1;
                        sq_next    = sq_reg + (tdpt_pkg::SQW'(d_reg) << 1)
                                     + tdpt_pkg::SQW'(1);
                        state_next = tdpt_pkg::ST_CHECK;
                    end
                end
            end
            tdpt_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = res_reg;
                    state_next     = tdpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase

        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                is_prime_next  = fin_val;
                state_next     = tdpt_pkg::ST_IDLE;
            end
            else
            begin
                res_next   = fin_val;
                state_next = tdpt_pkg::ST_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        sq_reg       <= sq_next;
        rem_reg      <= rem_next;
        bit_cnt_reg  <= bit_cnt_next;
        res_reg      <= res_next;
        is_prime_reg <= is_prime_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/tdpt_checker.sv
// port-level checks for the trial division prime test
`default_nettype none

module tdpt_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic [tdpt_pkg::CAND_W-1:0] candidate,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic                        is_prime
);

    // busy right after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // a result never appears the cycle after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

    // zero and one finish quickly as not prime
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid
        && (candidate == 32'd0 || candidate == 32'd1)
        |=> ##1 out_valid && !is_prime)
        else $error("zero or one not reported as not prime");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(is_prime))
        else $error("stalled result changed");

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (.*);

`default_nettype wire

FILE: test/prime_result_checker.sv
// checker for the trial division prime test: predicts is_prime per candidate and compares

module prime_result_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_stall,
    input  wire logic [tdpt_pkg::CAND_W-1:0] candidate,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic                        is_prime,
    output int                               mismatches,
    output int                               outstanding
);

    bit expected_is_prime[$];
    bit oldest_is_prime;

    function automatic bit trial_division_verdict(logic [tdpt_pkg::CAND_W-1:0] value);
        longint unsigned n;
        longint unsigned d;
        n = 64'(value);
        if (tdpt_pkg::WIDTH < 64)
        begin
            n = n & ((64'd1 << tdpt_pkg::WIDTH) - 64'd1);
        end
        if (n < 2)
        begin
            return 1'b0;
        end
        if (n < 4)
        begin
            return 1'b1;
        end
        if ((n % 2) == 0 || (n % 3) == 0)
        begin
            return 1'b0;
        end
        for (d = 5; d <= n / d; d += 6)
        begin
            if ((n % d) == 0 || (n % (d + 2)) == 0)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_is_prime.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_is_prime.push_back(trial_division_verdict(candidate));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_is_prime.size() == 0)
                begin
                    $error("is_prime word with nothing expected: expected none, actual %0b",
                           is_prime);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    oldest_is_prime = expected_is_prime.pop_front();
                    if (is_prime !== oldest_is_prime)
                    begin
                        $error("is_prime mismatch: expected %0b, actual %0b",
                               oldest_is_prime, is_prime);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            outstanding <= expected_is_prime.size();
        end
    end

endmodule

FILE: test/tb_trial_division_prime_test_core.sv
// testbench top for the trial division prime test core: stimulus, flow control and verdict

module tb_trial_division_prime_test_core;

    localparam int CW = tdpt_pkg::CAND_W;
    localparam int RANDOM_WORDS = 71;
    localparam int FILL_HOLD = 5000;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [CW-1:0] candidate;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          is_prime;

    int mismatches;
    int outstanding;

    bit fill_phase;
    bit fill_done = 1'b0;
    int stall_left = 0;
    int calm_left = 0;

    logic [CW-1:0] directed_words[$];

    trial_division_prime_test_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime)
    );

    prime_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .candidate   (candidate),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_prime    (is_prime),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 80);
    endfunction

    // mostly small candidates: every trial divisor up to the root costs a full remainder
    function automatic logic [CW-1:0] random_candidate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return CW'($urandom_range(0, 1023));
        end
        if (r < 85)
        begin
            return CW'($urandom_range(1024, 16383));
        end
        return CW'($urandom_range(16384, 262143));
    endfunction

    task automatic offer_word(input logic [CW-1:0] value);
        in_valid  <= 1'b1;
        candidate <= value;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    // receiver flow control, one decision per cycle
    always @(negedge clk)
    begin
        if (fill_phase && !fill_done)
        begin
            fill_done  <= 1'b1;
            stall_left <= FILL_HOLD - 1;
            out_stall  <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (calm_left > 0)
        begin
            calm_left <= calm_left - 1;
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            calm_left <= $urandom_range(100, 400);
            out_stall <= 1'b0;
        end
        else
        begin
            stall_left <= idle_cycles();
            out_stall  <= ($urandom_range(0, 99) < 30);
        end
    end

    initial
    begin
        int i;
        int calm_words;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        candidate  = '0;
        fill_phase = 1'b0;
        calm_words = 0;

        directed_words = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
            32'd25, 32'd49, 32'd97, 32'd121, 32'd1369, 32'd63001, 32'd65521,
            32'd65535, 32'd65536, 32'd65537, 32'd999999, 32'd1000003,
            32'hFFFF_FFFF
        };

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        foreach (directed_words[k])
        begin
            idle_sender(idle_cycles());
            offer_word(directed_words[k]);
        end

        // sender waits for every result before the fill test
        idle_sender(1);
        drain_results();

        // receiver holds off while small words go in back to back
        fill_phase <= 1'b1;
        for (i = 0; i < 6; i++)
        begin
            offer_word(CW'($urandom_range(100, 400)));
        end

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (calm_words > 0)
            begin
                calm_words--;
            end
            else if ($urandom_range(0, 99) < 8)
            begin
                calm_words = $urandom_range(5, 12);
            end
            else
            begin
                idle_sender(idle_cycles());
            end
            offer_word(random_candidate());
        end

        in_valid <= 1'b0;
        drain_results();
        repeat (100) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb_trial_division_prime_test_core OK");
        end
        else
        begin
            $display("tb_trial_division_prime_test_core NOT OK");
        end
        $finish;
    end

    initial
    begin
        #40000000;
        $display("tb_trial_division_prime_test_core NOT OK");
        $finish;
    end

endmodule
